// ----- rtl/shv_pkg.sv -----
// ----------------------------------------------------------------------------
// shv_pkg
// Shared widths, constants and fixed-point helpers for the headless vector
// endpoint pipeline.
// ----------------------------------------------------------------------------
package shv_pkg;

   localparam int ANGLE_BITS      = 16;
   localparam int COORD_FRAC_BITS = 15;
   localparam int CORDIC_STEPS    = 20;
   localparam int CORDIC_LAT      = CORDIC_STEPS + 2;
   localparam int GEOM_LAT        = 8;
   localparam int TOTAL_LAT       = CORDIC_LAT + GEOM_LAT;

   localparam int QW     = 36;   // Q30 working word with headroom
   localparam int OUT_W  = 18;
   localparam int REG_W  = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef logic signed [QW-1:0]    q30_type;
   typedef logic signed [OUT_W-1:0] coord_type;
   typedef logic [ANGLE_BITS-1:0]   angle_type;
   typedef logic [REG_W-1:0]        csr_reg_type;

   localparam logic CSR_HALF_LENGTH = 1'b0;
   localparam logic CSR_LIFT        = 1'b1;

   // byte addresses of the registers
   localparam logic [CSR_AW-1:0] CSR_HALF_LENGTH_ADDR = {CSR_HALF_LENGTH, 2'b00};
   localparam logic [CSR_AW-1:0] CSR_LIFT_ADDR        = {CSR_LIFT, 2'b00};

   localparam csr_reg_type HALF_LENGTH_RST = 16'd32768;
   localparam csr_reg_type LIFT_RST        = 16'd66;

   localparam q30_type Q30_ONE   = QW'(64'sd1073741824);
   localparam q30_type GAIN_INV  = QW'(64'sd652032875);
   localparam q30_type ROUND30   = QW'(64'sd536870912);

   // atan(2^-i) in units of 2^-32 turn
   localparam q30_type ATAN_TAB [CORDIC_STEPS] = '{
      36'sd536870912, 36'sd316933406, 36'sd167458907, 36'sd85004756,
      36'sd42667331,  36'sd21354465,  36'sd10679838,  36'sd5340245,
      36'sd2670163,   36'sd1335087,   36'sd667544,    36'sd333772,
      36'sd166886,    36'sd83443,     36'sd41722,     36'sd20861,
      36'sd10430,     36'sd5215,      36'sd2608,      36'sd1304
   };

   localparam int FIN_SH  = 30 - COORD_FRAC_BITS;
   localparam int FIN_RND = (COORD_FRAC_BITS < 30) ? (2 ** (29 - COORD_FRAC_BITS)) : 0;
   localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
   localparam int OUT_MIN = -(2 ** (OUT_W - 1));

   // Q30 x Q30 -> Q30, round half up (floor shift)
   function automatic q30_type mul30(input q30_type a, input q30_type b);
      logic signed [2*QW-1:0] p;
      p = (a * b) + (2*QW)'(ROUND30);
      return p[QW+29:30];
   endfunction

   // Q30 -> Q2.F with rounding and saturation
   function automatic coord_type finish(input q30_type v);
      logic signed [QW:0] t;
      t = {v[QW-1], v} + (QW+1)'(FIN_RND);
      t = t >>> FIN_SH;
      if (t > (QW+1)'(OUT_MAX)) begin
         return coord_type'(OUT_MAX);
      end
      if (t < (QW+1)'(OUT_MIN)) begin
         return coord_type'(OUT_MIN);
      end
      return t[OUT_W-1:0];
   endfunction

endpackage

// ----- rtl/sphere_headless_vector_endpoints.sv -----
// ----------------------------------------------------------------------------
// sphere_headless_vector_endpoints
// Headless polarization vector endpoints on the unit sphere.
// ----------------------------------------------------------------------------
// Takes one (colatitude, longitude, polarization angle) transfer per cycle and
// returns one pair of line endpoints per transfer, in order (pipelined
// CORDIC, three units side by side, then 8 geometry stages: point and
// perpendicular vectors, pairwise products, axis-angle matrix for both
// rotations, matrix times vector, scaling, round/saturate). Sustained rate
// is one transfer per clock while req_stall is low. A one-entry skid register
// behind the last stage takes a result when rsp_stall is high; only while it
// is full does req_stall rise and the pipeline freeze. Coordinates are signed
// Q2.15, saturated. half_length (addr 0x0) and lift (addr 0x4) are 16-bit
// Q0.16 registers written over the APB port; write them only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module sphere_headless_vector_endpoints (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  shv_pkg::angle_type          req_colatitude,
   input  shv_pkg::angle_type          req_longitude,
   input  shv_pkg::angle_type          req_pol_angle,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output shv_pkg::coord_type          rsp_first_x,
   output shv_pkg::coord_type          rsp_first_y,
   output shv_pkg::coord_type          rsp_first_z,
   output shv_pkg::coord_type          rsp_second_x,
   output shv_pkg::coord_type          rsp_second_y,
   output shv_pkg::coord_type          rsp_second_z,
   // configuration
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [shv_pkg::CSR_AW-1:0]  paddr,
   input  logic [shv_pkg::CSR_DW-1:0]  pwdata,
   output logic [shv_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import shv_pkg::*;

   // ---------------- configuration registers ----------------
   csr_reg_type half_length_ff;
   csr_reg_type lift_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_length_ff <= HALF_LENGTH_RST;
         lift_ff        <= LIFT_RST;
      end else if (csr_wr) begin
         unique case (paddr[2])
            CSR_HALF_LENGTH: half_length_ff <= pwdata[REG_W-1:0];
            CSR_LIFT:        lift_ff        <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_HALF_LENGTH: prdata = CSR_DW'(half_length_ff);
         CSR_LIFT:        prdata = CSR_DW'(lift_ff);
         default:         prdata = '0;
      endcase
   end

   // Q30 forms of the registers; 1+lift fits since lift < 1
   q30_type scale;
   q30_type one_plus_lift;
   assign scale         = QW'({half_length_ff, 14'b0});
   assign one_plus_lift = QW'({1'b1, lift_ff, 14'b0});

   // ---------------- pipeline control ----------------
   logic                 pipe_en;
   logic [TOTAL_LAT-1:0] vld_ff;
   logic                 skid_vld_ff;

   assign pipe_en   = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_valid};
      end
   end

   // ---------------- sine / cosine ----------------
   q30_type ct, st, cp, sp, cg, sg;

   shv_cordic u_cordic_theta (
      .clock(clock), .en(pipe_en), .angle_in(req_colatitude),
      .cos_out(ct), .sin_out(st)
   );
   shv_cordic u_cordic_phi (
      .clock(clock), .en(pipe_en), .angle_in(req_longitude),
      .cos_out(cp), .sin_out(sp)
   );
   shv_cordic u_cordic_psi (
      .clock(clock), .en(pipe_en), .angle_in(req_pol_angle),
      .cos_out(cg), .sin_out(sg)
   );

   // ---------------- S1: point / perpendicular vectors ----------------
   // index j: 0 = polarization angle, 1 = plus half turn (exact negation)
   q30_type e1_ff [3];
   q30_type vin1_ff [3];
   q30_type c1_ff [2];
   q30_type s1_ff [2];
   q30_type u1_ff [2];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e1_ff[0]   <= mul30(cp, st);
         e1_ff[1]   <= mul30(sp, st);
         e1_ff[2]   <= ct;
         vin1_ff[0] <= -mul30(cp, ct);
         vin1_ff[1] <= -mul30(sp, ct);
         vin1_ff[2] <= st;
         c1_ff[0]   <= cg;
         c1_ff[1]   <= -cg;
         s1_ff[0]   <= sg;
         s1_ff[1]   <= -sg;
         u1_ff[0]   <= Q30_ONE - cg;
         u1_ff[1]   <= Q30_ONE + cg;
      end
   end

   // ---------------- S2: pairwise products ----------------
   // pp order: e0e0, e0e1, e0e2, e1e1, e1e2, e2e2
   q30_type pp2_ff [6];
   q30_type es2_ff [2][3];
   q30_type base2_ff [3];
   q30_type vin2_ff [3];
   q30_type c2_ff [2];
   q30_type u2_ff [2];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pp2_ff[0] <= mul30(e1_ff[0], e1_ff[0]);
         pp2_ff[1] <= mul30(e1_ff[0], e1_ff[1]);
         pp2_ff[2] <= mul30(e1_ff[0], e1_ff[2]);
         pp2_ff[3] <= mul30(e1_ff[1], e1_ff[1]);
         pp2_ff[4] <= mul30(e1_ff[1], e1_ff[2]);
         pp2_ff[5] <= mul30(e1_ff[2], e1_ff[2]);
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 3; k++) begin
               es2_ff[j][k] <= mul30(e1_ff[k], s1_ff[j]);
            end
            c2_ff[j] <= c1_ff[j];
            u2_ff[j] <= u1_ff[j];
         end
         for (int k = 0; k < 3; k++) begin
            base2_ff[k] <= mul30(one_plus_lift, e1_ff[k]);
            vin2_ff[k]  <= vin1_ff[k];
         end
      end
   end

   // ---------------- S3: times (1 - cos) ----------------
   q30_type pu3_ff [2][6];
   q30_type es3_ff [2][3];
   q30_type base3_ff [3];
   q30_type vin3_ff [3];
   q30_type c3_ff [2];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < 2; j++) begin
            for (int p = 0; p < 6; p++) begin
               pu3_ff[j][p] <= mul30(pp2_ff[p], u2_ff[j]);
            end
            for (int k = 0; k < 3; k++) begin
               es3_ff[j][k] <= es2_ff[j][k];
            end
            c3_ff[j] <= c2_ff[j];
         end
         for (int k = 0; k < 3; k++) begin
            base3_ff[k] <= base2_ff[k];
            vin3_ff[k]  <= vin2_ff[k];
         end
      end
   end

   // ---------------- S4: matrix entries ----------------
   q30_type a4_ff [2][9];
   q30_type base4_ff [3];
   q30_type vin4_ff [3];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < 2; j++) begin
            a4_ff[j][0] <= c3_ff[j] + pu3_ff[j][0];
            a4_ff[j][1] <= pu3_ff[j][1] + es3_ff[j][2];
            a4_ff[j][2] <= pu3_ff[j][2] - es3_ff[j][1];
            a4_ff[j][3] <= pu3_ff[j][1] - es3_ff[j][2];
            a4_ff[j][4] <= c3_ff[j] + pu3_ff[j][3];
            a4_ff[j][5] <= pu3_ff[j][4] + es3_ff[j][0];
            a4_ff[j][6] <= pu3_ff[j][2] + es3_ff[j][1];
            a4_ff[j][7] <= pu3_ff[j][4] - es3_ff[j][0];
            a4_ff[j][8] <= c3_ff[j] + pu3_ff[j][5];
         end
         for (int k = 0; k < 3; k++) begin
            base4_ff[k] <= base3_ff[k];
            vin4_ff[k]  <= vin3_ff[k];
         end
      end
   end

   // ---------------- S5: matrix times vector, products ----------------
   q30_type av5_ff [2][9];
   q30_type base5_ff [3];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < 2; j++) begin
            for (int m = 0; m < 9; m++) begin
               av5_ff[j][m] <= mul30(a4_ff[j][m], vin4_ff[m % 3]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            base5_ff[k] <= base4_ff[k];
         end
      end
   end

   // ---------------- S6: row sums ----------------
   q30_type r6_ff [2][3];
   q30_type base6_ff [3];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < 2; j++) begin
            for (int r = 0; r < 3; r++) begin
               r6_ff[j][r] <= av5_ff[j][3*r] + av5_ff[j][3*r+1] + av5_ff[j][3*r+2];
            end
         end
         for (int k = 0; k < 3; k++) begin
            base6_ff[k] <= base5_ff[k];
         end
      end
   end

   // ---------------- S7: scale rotated vectors ----------------
   q30_type sr7_ff [2][3];
   q30_type base7_ff [3];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < 2; j++) begin
            for (int r = 0; r < 3; r++) begin
               sr7_ff[j][r] <= mul30(scale, r6_ff[j][r]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            base7_ff[k] <= base6_ff[k];
         end
      end
   end

   // ---------------- S8: endpoint, round, saturate ----------------
   coord_type out8_ff [2][3];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < 2; j++) begin
            for (int r = 0; r < 3; r++) begin
               out8_ff[j][r] <= finish(base7_ff[r] + sr7_ff[j][r]);
            end
         end
      end
   end

   // ---------------- skid register ----------------
   // catches the last stage when the consumer stalls; always older than it
   coord_type skid_ff [2][3];
   logic      out_vld;

   assign out_vld = vld_ff[TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         skid_vld_ff <= rsp_stall;
      end else begin
         skid_vld_ff <= out_vld & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_ff <= out8_ff;
      end
   end

   assign rsp_valid    = skid_vld_ff | out_vld;
   assign rsp_first_x  = skid_vld_ff ? skid_ff[0][0] : out8_ff[0][0];
   assign rsp_first_y  = skid_vld_ff ? skid_ff[0][1] : out8_ff[0][1];
   assign rsp_first_z  = skid_vld_ff ? skid_ff[0][2] : out8_ff[0][2];
   assign rsp_second_x = skid_vld_ff ? skid_ff[1][0] : out8_ff[1][0];
   assign rsp_second_y = skid_vld_ff ? skid_ff[1][1] : out8_ff[1][1];
   assign rsp_second_z = skid_vld_ff ? skid_ff[1][2] : out8_ff[1][2];

endmodule

// ----- rtl/shv_cordic.sv -----
// ----------------------------------------------------------------------------
// shv_cordic
// Pipelined rotation-mode CORDIC: angle in turns to cosine and sine in Q30.
// ----------------------------------------------------------------------------
module shv_cordic (
   input  logic               clock,
   input  logic               en,
   input  shv_pkg::angle_type angle_in,
   output shv_pkg::q30_type   cos_out,
   output shv_pkg::q30_type   sin_out
);
   import shv_pkg::*;

   logic [31:0] phase;
   logic [31:0] phase_rnd;
   logic [1:0]  quad;
   logic [31:0] rem;

   q30_type    x_ff [0:CORDIC_STEPS];
   q30_type    y_ff [0:CORDIC_STEPS];
   q30_type    z_ff [0:CORDIC_STEPS];
   logic [1:0] q_ff [0:CORDIC_STEPS];
   q30_type    cos_ff;
   q30_type    sin_ff;

   // nearest quarter turn out, remainder in [-1/8, 1/8) turn
   assign phase     = {angle_in, {(32-ANGLE_BITS){1'b0}}};
   assign phase_rnd = phase + 32'h2000_0000;
   assign quad      = phase_rnd[31:30];
   assign rem       = phase - {quad, 30'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= GAIN_INV;
         y_ff[0] <= '0;
         z_ff[0] <= {{(QW-32){rem[31]}}, rem};
         q_ff[0] <= quad;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_TAB[i];
            end
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   // fold the quadrant back in
   always_ff @(posedge clock) begin
      if (en) begin
         unique case (q_ff[CORDIC_STEPS])
            2'd0: begin
               cos_ff <= x_ff[CORDIC_STEPS];
               sin_ff <= y_ff[CORDIC_STEPS];
            end
            2'd1: begin
               cos_ff <= -y_ff[CORDIC_STEPS];
               sin_ff <= x_ff[CORDIC_STEPS];
            end
            2'd2: begin
               cos_ff <= -x_ff[CORDIC_STEPS];
               sin_ff <= -y_ff[CORDIC_STEPS];
            end
            default: begin
               cos_ff <= y_ff[CORDIC_STEPS];
               sin_ff <= -x_ff[CORDIC_STEPS];
            end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- rtl/shv_checker.sv -----
// ----------------------------------------------------------------------------
// shv_checker
// Port-level checks for the headless vector endpoint block.
// ----------------------------------------------------------------------------
module shv_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        pready
);

   // nothing comes out right after reset
   a_rst_quiet: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result lost");

   // input is held off only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // stall on the input follows a stalled output
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall without output backpressure");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind sphere_headless_vector_endpoints shv_checker u_shv_checker (.*);
